FILE: hdl/wgbm_pkg.sv
// Shared types and constants for the wildcard gap byte matcher.
// Depends on nothing; every other file in hdl imports it.
package wgbm_pkg;

   localparam int TERM_W         = 10;
   localparam int TERMS_PER_WORD = 6;
   localparam int CSR_DATA_W     = 60;
   localparam int POS_W          = 4;
   localparam int LIMIT_W        = 16;
   localparam int ADDR_W         = 32;
   localparam int RUN_W          = 32;

   localparam int TERM_GAP_BIT  = 9;
   localparam int TERM_WILD_BIT = 8;

   typedef logic [TERM_W-1:0] term_type;

   typedef enum logic [1:0] {
      CSR_TERMS_LOW,
      CSR_TERMS_HIGH,
      CSR_PATTERN_LENGTH,
      CSR_MATCH_LIMIT
   } csr_index_type;

   typedef struct packed {
      logic [7:0]        data_byte;
      logic [ADDR_W-1:0] byte_address;
      logic [7:0]        lookahead_byte;
      logic              lookahead_valid;
      logic              first_byte;
   } item_type;

   typedef struct packed {
      logic [POS_W-1:0]   term_position;
      logic [RUN_W-1:0]   run_length;
      logic [ADDR_W-1:0]  candidate_start;
      logic [LIMIT_W-1:0] found_count;
      logic               halted;
   } match_state_type;

   typedef struct packed {
      logic [ADDR_W-1:0]  match_start;
      logic [RUN_W-1:0]   match_length;
      logic [LIMIT_W-1:0] match_number;
      logic               limit_reached;
   } result_type;

endpackage

FILE: hdl/wgbm_step.sv
// One matching step: next search state and an optional match report.
// Purely combinational; depends on wgbm_pkg.
module wgbm_step #(
   parameter int PATTERN_TERMS = 12
) (
   input  wgbm_pkg::term_type        terms [PATTERN_TERMS],
   input  logic [wgbm_pkg::POS_W-1:0] pattern_length,
   input  logic [wgbm_pkg::LIMIT_W-1:0] match_limit,
   input  wgbm_pkg::item_type        item,
   input  wgbm_pkg::match_state_type state_cur,
   output wgbm_pkg::match_state_type state_next,
   output logic                      result_valid,
   output wgbm_pkg::result_type      result
);
   import wgbm_pkg::*;

   localparam logic [POS_W-1:0] MAX_LEN = POS_W'(PATTERN_TERMS);

   // Terms past the array read as zero.
   function automatic term_type term_sel(input term_type t [PATTERN_TERMS],
                                         input logic [POS_W-1:0] pos);
      term_type r;
      r = '0;
      for (int k = 0; k < PATTERN_TERMS; k++) begin
         if (pos == POS_W'(k)) begin
            r = t[k];
         end
      end
      return r;
   endfunction

   logic [POS_W-1:0]     len;
   logic [LIMIT_W-1:0]   limit;
   match_state_type      s;
   term_type             term;
   term_type             next_term;
   term_type             prev_term;
   logic [7:0]           next_byte;
   logic [7:0]           prev_byte;
   logic [POS_W-1:0]     pos_inc;
   logic [RUN_W-1:0]     run_inc;
   logic                 found;
   logic                 skip;
   logic                 gap_ok;
   logic                 last_hit;

   always_comb begin
      if (pattern_length == '0) begin
         len = POS_W'(1);
      end else if (pattern_length > MAX_LEN) begin
         len = MAX_LEN;
      end else begin
         len = pattern_length;
      end
      limit = (match_limit == '0) ? LIMIT_W'(1) : match_limit;
   end

   always_comb begin
      s = state_cur;
      if (item.first_byte) begin
         s.term_position   = '0;
         s.run_length      = '0;
         s.candidate_start = item.byte_address;
         s.found_count     = '0;
         s.halted          = 1'b0;
      end
      // A pattern shortened under a partial match drops it.
      if (s.term_position >= len) begin
         s.term_position   = '0;
         s.run_length      = '0;
         s.candidate_start = item.byte_address;
      end

      term      = term_sel(terms, s.term_position);
      next_term = term_sel(terms, s.term_position + POS_W'(1));
      prev_term = term_sel(terms, s.term_position - POS_W'(1));
      next_byte = next_term[7:0];
      prev_byte = prev_term[7:0];
      pos_inc   = s.term_position + POS_W'(1);
      run_inc   = (&s.run_length) ? s.run_length : s.run_length + RUN_W'(1);
      gap_ok    = (s.term_position != '0) && (pos_inc < len) && item.lookahead_valid;

      found = 1'b0;
      skip  = 1'b0;
      if (term[TERM_GAP_BIT]) begin
         if (gap_ok) begin
            if (item.lookahead_byte == next_byte) begin
               found = 1'b1;
            end else if (item.data_byte != prev_byte) begin
               skip = 1'b1;
            end
         end
      end else if (term[TERM_WILD_BIT] || (item.data_byte == term[7:0])) begin
         found = 1'b1;
      end
      last_hit = found && (pos_inc >= len);

      result.match_start   = s.candidate_start;
      result.match_length  = run_inc;
      result.match_number  = s.found_count;
      result.limit_reached =
         ({1'b0, s.found_count} + (LIMIT_W+1)'(1)) >= {1'b0, limit};
      result_valid = 1'b0;

      state_next = s;
      if (s.halted) begin
         // A halted search ignores everything but a new first byte.
         state_next = s;
      end else if (skip) begin
         state_next.run_length = run_inc;
      end else if (found && !last_hit) begin
         state_next.term_position = pos_inc;
         state_next.run_length    = run_inc;
      end else begin
         if (last_hit) begin
            result_valid           = 1'b1;
            state_next.found_count = s.found_count + LIMIT_W'(1);
            state_next.halted      = result.limit_reached;
         end
         state_next.term_position   = '0;
         state_next.run_length      = '0;
         state_next.candidate_start = item.byte_address + ADDR_W'(1);
      end
   end

endmodule

FILE: hdl/wildcard_gap_byte_matcher_top.sv
// Wildcard gap byte matcher, top level: register file, request stage, result stage.
// A request is held in the request stage, and its report is registered in the result stage.
// Throughput: one request per cycle while the result channel is not stalled.
// Reset clears the search state and both stages and returns the pattern registers
// to their defaults (all terms zero, length 1, match limit 1). Depends on wgbm_pkg, wgbm_step.
module wildcard_gap_byte_matcher_top #(
   parameter int PATTERN_TERMS = 12
) (
   input  logic                            clock,
   input  logic                            reset,
   // Configuration write channel.
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  wgbm_pkg::csr_index_type         csr_index,
   input  logic [wgbm_pkg::CSR_DATA_W-1:0] csr_data,
   // Request channel: one memory byte per request.
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [7:0]                      req_data_byte,
   input  logic [wgbm_pkg::ADDR_W-1:0]     req_byte_address,
   input  logic [7:0]                      req_lookahead_byte,
   input  logic                            req_lookahead_valid,
   input  logic                            req_first_byte,
   // Result channel: one report per full match.
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [wgbm_pkg::ADDR_W-1:0]     rsp_match_start,
   output logic [wgbm_pkg::RUN_W-1:0]      rsp_match_length,
   output logic [wgbm_pkg::LIMIT_W-1:0]    rsp_match_number,
   output logic                            rsp_limit_reached
);
   import wgbm_pkg::*;

   // Pattern registers. Each term holds its byte, a wildcard bit and a gap bit.
   term_type           terms_ff [PATTERN_TERMS];
   logic [POS_W-1:0]   pattern_length_ff;
   logic [LIMIT_W-1:0] match_limit_ff;

   // Request stage.
   logic     req_valid_ff;
   item_type req_item_ff;

   // Search state carried from one byte to the next.
   match_state_type state_ff;
   match_state_type state_in;

   // Result stage.
   logic       rsp_valid_ff;
   result_type rsp_result_ff;
   logic       result_valid_in;
   result_type result_in;

   logic csr_write;
   logic out_free;
   logic advance;

   // The register file takes writes at any time; software must write only while idle, which the block does not enforce.
   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   for (genvar k = 0; k < PATTERN_TERMS; k++) begin : g_term
      always_ff @(posedge clock) begin
         if (reset) begin
            terms_ff[k] <= '0;
         end else if (csr_write) begin
            if (k < TERMS_PER_WORD) begin
               if (csr_index == CSR_TERMS_LOW) begin
                  terms_ff[k] <= csr_data[TERM_W*(k % TERMS_PER_WORD) +: TERM_W];
               end
            end else begin
               if (csr_index == CSR_TERMS_HIGH) begin
                  terms_ff[k] <= csr_data[TERM_W*(k % TERMS_PER_WORD) +: TERM_W];
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_length_ff <= POS_W'(1);
         match_limit_ff    <= LIMIT_W'(1);
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_PATTERN_LENGTH: pattern_length_ff <= csr_data[POS_W-1:0];
            CSR_MATCH_LIMIT:    match_limit_ff    <= csr_data[LIMIT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // The request stage moves on whenever the result register is empty or being
   // drained, so a stalled result holds the request stage and, once it is full, the request channel.
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign advance   = req_valid_ff && out_free;
   assign req_ready = !req_valid_ff || out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else if (req_ready) begin
         req_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         req_item_ff.data_byte       <= req_data_byte;
         req_item_ff.byte_address    <= req_byte_address;
         req_item_ff.lookahead_byte  <= req_lookahead_byte;
         req_item_ff.lookahead_valid <= req_lookahead_valid;
         req_item_ff.first_byte      <= req_first_byte;
      end
   end

   // The matching step itself: term compare, gap lookahead, run count and report.
   wgbm_step #(
      .PATTERN_TERMS(PATTERN_TERMS)
   ) u_step (
      .terms          (terms_ff),
      .pattern_length (pattern_length_ff),
      .match_limit    (match_limit_ff),
      .item           (req_item_ff),
      .state_cur      (state_ff),
      .state_next     (state_in),
      .result_valid   (result_valid_in),
      .result         (result_in)
   );

   // The search state updates in the same cycle the byte is processed, so the
   // next byte sees it immediately.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else if (advance) begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= result_valid_in;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && result_valid_in) begin
         rsp_result_ff <= result_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_match_start   = rsp_result_ff.match_start;
   assign rsp_match_length  = rsp_result_ff.match_length;
   assign rsp_match_number  = rsp_result_ff.match_number;
   assign rsp_limit_reached = rsp_result_ff.limit_reached;

endmodule
